>>> sv/twt_pkg.sv
// Shared constants, types and helpers of the trailing whitespace trimmer.
package twt_pkg;

  // Depth of the held whitespace run.
  localparam int unsigned RunDepth = 32;
  localparam int unsigned RunIdxW  = (RunDepth > 1) ? $clog2(RunDepth) : 1;
  localparam int unsigned RunCntW  = $clog2(RunDepth + 1);

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;

  typedef enum logic {
    KIND_SPACE = 1'b0,
    KIND_TAB   = 1'b1
  } kind_e;

  // Commands from the sequencer to the run store.
  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    kind_e kind;
  } run_ctrl_t;

  // What the run store shows back.
  typedef struct packed {
    logic [RunCntW-1:0] count;
    logic               full;
    kind_e              head_kind;
  } run_stat_t;

  function automatic logic [7:0] kind_byte(kind_e kind);
    logic [7:0] b;
    b = (kind == KIND_TAB) ? ChTab : ChSpace;
    return b;
  endfunction

endpackage

>>> sv/twt_run_store.sv
// Circular store of held space/tab kinds with head pointer and fill count.
module twt_run_store
  import twt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  run_ctrl_t ctrl_i,
  output run_stat_t stat_o
);

  kind_e              kinds_q [RunDepth];
  kind_e              head_kind_q;
  logic [RunIdxW-1:0] head_q, head_d;
  logic [RunCntW-1:0] count_q, count_d;
  logic [RunCntW:0]   tail_sum;
  logic [RunCntW:0]   tail_wrap;
  logic [RunIdxW-1:0] tail;

  // tail = (head + count) mod depth; the sum stays below twice the depth
  always_comb begin
    tail_sum  = (RunCntW + 1)'(head_q) + (RunCntW + 1)'(count_q);
    tail_wrap = (tail_sum >= (RunCntW + 1)'(RunDepth)) ?
                tail_sum - (RunCntW + 1)'(RunDepth) : tail_sum;
    tail      = tail_wrap[RunIdxW-1:0];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == RunIdxW'(RunDepth - 1)) ? '0 : head_q + RunIdxW'(1);
    end
    priority if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + RunCntW'(1);
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - RunCntW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // when full, tail equals head: the new kind takes the slot being popped.
  // The head kind is read ahead at the next head, with the write forwarded
  // when a push lands on it (push into an empty run).
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      kinds_q[tail] <= ctrl_i.kind;
    end
    priority if (ctrl_i.push && (tail == head_d)) begin
      head_kind_q <= ctrl_i.kind;
    end else begin
      head_kind_q <= kinds_q[head_d];
    end
  end

  assign stat_o.count     = count_q;
  assign stat_o.full      = (count_q == RunCntW'(RunDepth));
  assign stat_o.head_kind = head_kind_q;

endmodule

>>> sv/trailing_whitespace_trimmer.sv
// Top level of the trailing whitespace trimmer: sequencer and output register.
//
// Text arrives one byte per item; spaces and tabs are held back in a run of
// up to RunDepth (32) entries and are dropped when a newline or an end item
// follows them. Any other byte releases the held run in arrival order and
// then passes itself on. A space or tab that arrives while the run is full
// pushes the oldest held byte out at once, flagged as overflowed. A newline,
// an end item, a space or tab, or an ordinary byte with an empty run is
// taken straight from the idle state; an ordinary byte behind held bytes
// keeps the input stalled while the sequencer moves one held byte a cycle,
// when the output is not stalled, from the run store's single read port
// into the output register, and then the byte itself.
// last_of_run marks the final result of each item; items that are held
// give no result at all. Carriage return is an ordinary byte.
module trailing_whitespace_trimmer
  import twt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_end_marker_o,
  output logic       overflowed_o,
  output logic       last_of_run_o
);

  // sequencer states
  localparam logic StIdle    = 1'b0;  // taking items
  localparam logic StRelease = 1'b1;  // draining the run, then the held byte

  logic       state_q, state_d;
  logic [7:0] byte_q, byte_d;     // ordinary byte waiting behind the run

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_end_q, out_ovf_q, out_last_q;

  logic       out_free;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_end, emit_ovf, emit_last;

  run_ctrl_t  run_ctrl;
  run_stat_t  run_stat;

  twt_run_store u_run_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (run_ctrl),
    .stat_o (run_stat)
  );

  // the output register can take a new item when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && out_free);

  always_comb begin
    state_d   = state_q;
    byte_d    = byte_q;
    run_ctrl  = '{push: 1'b0, pop: 1'b0, clear: 1'b0, kind: KIND_SPACE};
    emit      = 1'b0;
    emit_byte = '0;
    emit_end  = 1'b0;
    emit_ovf  = 1'b0;
    emit_last = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i && out_free) begin
          priority if (end_of_text_i) begin
            run_ctrl.clear = 1'b1;
            emit           = 1'b1;
            emit_end       = 1'b1;
            emit_last      = 1'b1;
          end else if (text_byte_i == ChNewline) begin
            run_ctrl.clear = 1'b1;
            emit           = 1'b1;
            emit_byte      = ChNewline;
            emit_last      = 1'b1;
          end else if (text_byte_i == ChSpace || text_byte_i == ChTab) begin
            run_ctrl.push = 1'b1;
            run_ctrl.kind = (text_byte_i == ChTab) ? KIND_TAB : KIND_SPACE;
            if (run_stat.full) begin
              // oldest held byte leaves early, the new one joins the run
              run_ctrl.pop = 1'b1;
              emit         = 1'b1;
              emit_byte    = kind_byte(run_stat.head_kind);
              emit_ovf     = 1'b1;
              emit_last    = 1'b1;
            end
          end else if (run_stat.count == '0) begin
            emit      = 1'b1;
            emit_byte = text_byte_i;
            emit_last = 1'b1;
          end else begin
            byte_d  = text_byte_i;
            state_d = StRelease;
          end
        end
      end
      StRelease: begin
        if (out_free) begin
          emit = 1'b1;
          if (run_stat.count != '0) begin
            run_ctrl.pop = 1'b1;
            emit_byte    = kind_byte(run_stat.head_kind);
          end else begin
            emit_byte = byte_q;
            emit_last = 1'b1;
            state_d   = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = out_free ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // out_* load only when a result enters the output slot; byte_q always loads
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (out_free && emit) begin
      out_byte_q <= emit_byte;
      out_end_q  <= emit_end;
      out_ovf_q  <= emit_ovf;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign is_end_marker_o = out_end_q;
  assign overflowed_o    = out_ovf_q;
  assign last_of_run_o   = out_last_q;

endmodule

>>> sv/twt_checker.sv
// Port-level checks on the trimmer, bound to its top level.
module twt_checker
  import twt_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] text_byte_i,
  input logic       end_of_text_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       is_end_marker_o,
  input logic       overflowed_o,
  input logic       last_of_run_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(is_end_marker_o) &&
      $stable(overflowed_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // an accepted end item shows up as the end marker on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_text_i |=>
      out_valid_o && is_end_marker_o && out_byte_o == 8'h00 &&
      last_of_run_o && !overflowed_o)
    else $error("end item not marked");

  // early release is a single space or tab closing its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o |->
      last_of_run_o && !is_end_marker_o &&
      (out_byte_o == ChSpace || out_byte_o == ChTab))
    else $error("bad overflow result");

  // results ahead of the last one are released spaces or tabs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |->
      !overflowed_o && !is_end_marker_o &&
      (out_byte_o == ChSpace || out_byte_o == ChTab))
    else $error("non-final result is not whitespace");

endmodule

bind trailing_whitespace_trimmer twt_checker u_twt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .text_byte_i     (text_byte_i),
  .end_of_text_i   (end_of_text_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .is_end_marker_o (is_end_marker_o),
  .overflowed_o    (overflowed_o),
  .last_of_run_o   (last_of_run_o)
);
